/* hw/rtl/prlq_pkg.sv */
// package: word types, config indexes, constants and sensitivity lookup for the link quality core
package prlq_pkg;

	typedef struct packed {
		logic signed [7:0] raw_snr;
		logic        [7:0] rssi_code;
	} pkt_t;

	typedef struct packed {
		logic signed [8:0] rssi_dbm;
		logic signed [7:0] snr_quarter_db;
		logic        [6:0] lq_pct;
	} res_t;

	typedef enum logic [1:0] {
		CFG_SPREADING_FACTOR = 2'd0,
		CFG_BW_IS_500        = 2'd1,
		CFG_HIGH_BAND        = 2'd2
	} cfg_index_t;

	// word handed to the quotient pipeline
	typedef struct packed {
		logic        [20:0] rem;
		logic        [14:0] den;
		logic               zero;
		logic               full;
		logic signed [8:0]  rssi;
		logic signed [7:0]  snr;
	} div_in_t;

	localparam logic        [3:0] SF_RESET        = 4'd8;
	localparam logic        [3:0] SF_MIN          = 4'd6;
	localparam logic        [3:0] SF_MAX          = 4'd12;
	localparam logic signed [8:0] FLOOR_HIGH_DBM  = -9'sd157;
	localparam logic signed [8:0] FLOOR_LOW_DBM   = -9'sd164;
	localparam logic signed [8:0] SENS_OFFSET     = 9'sd40;
	localparam logic signed [8:0] LQ_MAX_DBM      = 9'sd1;
	localparam logic        [6:0] LQ_FULL         = 7'd100;
	localparam logic        [6:0] LQ_ZERO         = 7'd0;
	localparam logic       [12:0] RECIP15         = 13'd4370;
	localparam int                RECIP_SHIFT     = 16;

	localparam logic signed [8:0] SENS_TABLE [7] = '{
		-9'sd109, -9'sd114, -9'sd117, -9'sd120, -9'sd123, -9'sd125, -9'sd128
	};

	function automatic logic signed [8:0] sens_lookup(input logic [3:0] sf, input logic bw,
			input logic signed [8:0] floor_dbm);
		logic signed [8:0] s;
		s = floor_dbm + SENS_OFFSET;
		if (bw && (sf >= SF_MIN) && (sf <= SF_MAX)) begin
			s = SENS_TABLE[3'(sf - SF_MIN)];
		end
		return s;
	endfunction

endpackage

/* hw/rtl/prlq_div.sv */
// three stage restoring divider producing the clamped link quality result word
module prlq_div import prlq_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_ready,
	input  div_in_t in_word,
	output logic    res_valid,
	input  logic    res_ready,
	output res_t    res
);

	typedef struct packed {
		logic        [21:0] rem;
		logic        [14:0] den;
		logic        [6:0]  quo;
		logic               zero;
		logic               full;
		logic signed [8:0]  rssi;
		logic signed [7:0]  snr;
	} div_stage_t;

	typedef struct packed {
		logic        bit_q;
		logic [21:0] rem;
	} div_step_t;

	function automatic div_step_t div_step(input logic [21:0] rem, input logic [21:0] dsh);
		div_step_t r;
		r.bit_q = (rem >= dsh);
		r.rem   = r.bit_q ? (rem - dsh) : rem;
		return r;
	endfunction

	logic       v_s5, v_s6, v_s7;
	logic       rdy_s5, rdy_s6, rdy_s7;
	div_stage_t d_s5, d_s6, d_s7;
	div_stage_t d5_c, d6_c, d7_c;
	div_step_t  st6, st5, st4, st3, st2, st1, st0;
	logic [21:0] den_a, den_b, den_c;

	assign rdy_s7   = ~v_s7 | res_ready;
	assign rdy_s6   = ~v_s6 | rdy_s7;
	assign rdy_s5   = ~v_s5 | rdy_s6;
	assign in_ready = rdy_s5;

	// quotient bits 6..4
	always_comb begin
		den_a     = 22'(in_word.den);
		st6       = div_step({1'b0, in_word.rem}, den_a << 6);
		st5       = div_step(st6.rem, den_a << 5);
		st4       = div_step(st5.rem, den_a << 4);
		d5_c.rem  = st4.rem;
		d5_c.den  = in_word.den;
		d5_c.quo  = {st6.bit_q, st5.bit_q, st4.bit_q, 4'b0};
		d5_c.zero = in_word.zero;
		d5_c.full = in_word.full;
		d5_c.rssi = in_word.rssi;
		d5_c.snr  = in_word.snr;
	end

	// quotient bits 3..2
	always_comb begin
		den_b    = 22'(d_s5.den);
		st3      = div_step(d_s5.rem, den_b << 3);
		st2      = div_step(st3.rem, den_b << 2);
		d6_c     = d_s5;
		d6_c.rem = st2.rem;
		d6_c.quo = {d_s5.quo[6:4], st3.bit_q, st2.bit_q, 2'b0};
	end

	// quotient bits 1..0
	always_comb begin
		den_c    = 22'(d_s6.den);
		st1      = div_step(d_s6.rem, den_c << 1);
		st0      = div_step(st1.rem, den_c);
		d7_c     = d_s6;
		d7_c.rem = st0.rem;
		d7_c.quo = {d_s6.quo[6:2], st1.bit_q, st0.bit_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else begin
			if (rdy_s5) v_s5 <= in_valid;
			if (rdy_s6) v_s6 <= v_s5;
			if (rdy_s7) v_s7 <= v_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s5) d_s5 <= d5_c;
		if (rdy_s6) d_s6 <= d6_c;
		if (rdy_s7) d_s7 <= d7_c;
	end

	always_comb begin
		res_valid          = v_s7;
		res.rssi_dbm       = d_s7.rssi;
		res.snr_quarter_db = d_s7.snr;
		if (d_s7.zero) begin
			res.lq_pct = LQ_ZERO;
		end else if (d_s7.full) begin
			res.lq_pct = LQ_FULL;
		end else begin
			res.lq_pct = d_s7.quo;
		end
	end

endmodule

/* hw/rtl/packet_rssi_link_quality_core.sv */
// top level: packet strength in dBm and link quality percentage from raw snr and rssi bytes
//
// One word is taken per clock cycle while no stall holds the pipeline, and each accepted word
// gives exactly one result word after front stages one to four and the three divider stages. Stage
// one forms the band floor, the sensitivity and both strength candidates, stage two finishes the
// divide by fifteen with a reciprocal multiply, stage three forms the span square and the linear
// term, stage four the numerator, and three divider stages produce the seven bit quotient two or
// three bits at a time. Each stage holds its word while the stage after it is full and stalled,
// so bubbles are squeezed out and a new word is accepted while a finished result is still
// waiting. The three configuration registers are written through their own port, always ready,
// and are meant to be changed only while no word is in flight.
module packet_rssi_link_quality_core import prlq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       pkt_valid,
	output logic       pkt_ready,
	input  pkt_t       pkt,
	output logic       res_valid,
	input  logic       res_ready,
	output res_t       res,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [1:0] cfg_index,
	input  logic [3:0] cfg_data
);

	logic [3:0] sf_q;
	logic       bw_q;
	logic       hb_q;

	logic signed [8:0]  floor_c, sens_c, rssi_n_c, rssi_p_c;
	logic signed [12:0] v_c;
	logic signed [10:0] w_c;
	logic        [10:0] wa_c;
	logic        [24:0] prod_c;
	logic signed [9:0]  gap_c;
	logic signed [15:0] t_c;
	logic        [15:0] den_c;
	logic signed [25:0] p_c;
	logic        [22:0] hd_c;
	logic signed [26:0] num_c;
	div_in_t            div_c;

	logic               v_s1, v_s2, v_s3, v_s4;
	logic               rdy_s1, rdy_s2, rdy_s3, rdy_s4;
	logic               div_ready;
	logic signed [7:0]  snr_s1, snr_s2, snr_s3;
	logic        [11:0] absv_s1;
	logic               vneg_s1;
	logic signed [8:0]  rssi_n_s1, rssi_s2, rssi_s3;
	logic        [7:0]  span_s1, span_s2;
	logic signed [9:0]  gap_s3;
	logic signed [15:0] t_s3;
	logic        [15:0] den_s3;
	div_in_t            div_s4;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sf_q <= SF_RESET;
			bw_q <= 1'b1;
			hb_q <= 1'b1;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_SPREADING_FACTOR: sf_q <= cfg_data;
				CFG_BW_IS_500:        bw_q <= cfg_data[0];
				CFG_HIGH_BAND:        hb_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign rdy_s4    = ~v_s4 | div_ready;
	assign rdy_s3    = ~v_s3 | rdy_s4;
	assign rdy_s2    = ~v_s2 | rdy_s3;
	assign rdy_s1    = ~v_s1 | rdy_s2;
	assign pkt_ready = rdy_s1;

	// stage one: floor, sensitivity, both strength candidates
	always_comb begin
		floor_c  = hb_q ? FLOOR_HIGH_DBM : FLOOR_LOW_DBM;
		sens_c   = sens_lookup(sf_q, bw_q, floor_c);
		v_c      = 13'(floor_c) * 13'sd15 + $signed({1'b0, pkt.rssi_code, 4'b0});
		w_c      = ((11'(floor_c) + $signed({3'b0, pkt.rssi_code})) <<< 2) + 11'(pkt.raw_snr);
		wa_c     = w_c[10] ? 11'(-w_c) : w_c;
		rssi_n_c = w_c[10] ? -$signed({1'b0, wa_c[9:2]}) : $signed({1'b0, wa_c[9:2]});
	end

	// stage two: truncated divide by fifteen
	always_comb begin
		prod_c   = 25'(absv_s1) * 25'(RECIP15);
		rssi_p_c = vneg_s1 ? -$signed({1'b0, prod_c[RECIP_SHIFT+7:RECIP_SHIFT]})
		                   : $signed({1'b0, prod_c[RECIP_SHIFT+7:RECIP_SHIFT]});
	end

	// stage three: gap, linear term, span square
	always_comb begin
		gap_c = 10'(LQ_MAX_DBM) - 10'(rssi_s2);
		t_c   = 16'sd25 * $signed({8'b0, span_s2}) + 16'sd75 * 16'(gap_c);
		den_c = 16'(span_s2) * 16'(span_s2);
	end

	// stage four: numerator and clamp flags
	always_comb begin
		p_c        = 26'(gap_s3) * 26'(t_s3);
		hd_c       = 23'(den_s3) * 23'd100;
		num_c      = $signed({4'b0, hd_c}) - 27'(p_c);
		div_c.rem  = num_c[20:0];
		div_c.den  = den_s3[14:0];
		div_c.zero = num_c[26] | (num_c == 27'sd0);
		div_c.full = p_c[25] | (p_c == 26'sd0);
		div_c.rssi = rssi_s3;
		div_c.snr  = snr_s3;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= pkt_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1) begin
			snr_s1    <= pkt.raw_snr;
			absv_s1   <= v_c[12] ? 12'(-v_c) : v_c[11:0];
			vneg_s1   <= v_c[12];
			rssi_n_s1 <= rssi_n_c;
			span_s1   <= 8'(LQ_MAX_DBM - sens_c);
		end
		if (rdy_s2) begin
			snr_s2  <= snr_s1;
			rssi_s2 <= snr_s1[7] ? rssi_n_s1 : rssi_p_c;
			span_s2 <= span_s1;
		end
		if (rdy_s3) begin
			snr_s3  <= snr_s2;
			rssi_s3 <= rssi_s2;
			gap_s3  <= gap_c;
			t_s3    <= t_c;
			den_s3  <= den_c;
		end
		if (rdy_s4) begin
			div_s4 <= div_c;
		end
	end

	prlq_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (v_s4),
		.in_ready  (div_ready),
		.in_word   (div_s4),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	a_lq_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res.lq_pct <= LQ_FULL))
		else $error("link quality above full scale");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(pkt_valid && pkt_ready) |=> v_s1)
		else $error("accepted word missing from first stage");

	a_s4_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && !div_ready) |=> (v_s4 && $stable(div_s4)))
		else $error("stalled numerator word changed");

	a_zero_full_excl: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> !(div_s4.zero && div_s4.full))
		else $error("clamp flags both set");

endmodule

/* tb/packet_rssi_link_quality_core_tb.sv */
// testbench: randomized and directed check of the packet rssi and link quality core
`timescale 1ns / 1ps

module packet_rssi_link_quality_core_tb import prlq_pkg::*; ();

	localparam int             BAND_FLOOR_HI   = -157;
	localparam int             BAND_FLOOR_LO   = -164;
	localparam int             FALLBACK_OFFSET = 40;
	localparam int             PEAK_DBM        = 1;
	localparam int             SF_LO           = 6;
	localparam int             SF_HI           = 12;
	localparam int             SF_SENS [7]     = '{-109, -114, -117, -120, -123, -125, -128};
	localparam logic [1:0]     CFG_INDEX_UNUSED = 2'd3;
	localparam int             N_PLANS         = 12;
	localparam int             ITEMS_PER_PLAN  = 145;
	localparam int             SETTLE_CYCLES   = 12;

	typedef struct {
		logic [3:0] sf;
		logic [3:0] bw;
		logic [3:0] hb;
	} reg_plan_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       pkt_valid = 1'b0;
	logic       pkt_ready;
	pkt_t       pkt = '0;
	logic       res_valid;
	logic       res_ready = 1'b0;
	res_t       res;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic [1:0] cfg_index = '0;
	logic [3:0] cfg_data = '0;

	logic [3:0] cur_sf = 4'd8;
	logic       cur_bw500 = 1'b1;
	logic       cur_high_band = 1'b1;

	pkt_t pkt_words[$];
	res_t lq_expected[$];
	int   tx_idle_pct = 14;
	int   rx_idle_pct = 68;
	int   n_pushed = 0;
	int   n_sent = 0;
	int   n_checked = 0;
	int   err_cnt = 0;

	reg_plan_t plans [N_PLANS] = '{
		'{4'd6,  4'd1, 4'd1}, '{4'd12, 4'd1, 4'd0}, '{4'd0,  4'd1, 4'd1},
		'{4'd15, 4'd1, 4'd0}, '{4'd9,  4'd0, 4'd1}, '{4'd7,  4'd0, 4'd0},
		'{4'd13, 4'd1, 4'd1}, '{4'd5,  4'd1, 4'd0}, '{4'd10, 4'hF, 4'hE},
		'{4'd11, 4'hE, 4'h3}, '{4'd8,  4'd1, 4'd1}, '{4'd12, 4'd1, 4'd1}
	};

	packet_rssi_link_quality_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pkt_valid (pkt_valid),
		.pkt_ready (pkt_ready),
		.pkt       (pkt),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	function automatic res_t estimate_link(pkt_t p);
		int     snr;
		int     raw;
		int     floor_dbm;
		int     sens;
		int     dbm;
		longint span;
		longint gap;
		longint den;
		longint num;
		longint q;
		res_t   r;
		snr = $signed(p.raw_snr);
		raw = p.rssi_code;
		floor_dbm = cur_high_band ? BAND_FLOOR_HI : BAND_FLOOR_LO;
		if (snr >= 0) begin
			dbm = (15 * floor_dbm + 16 * raw) / 15;
		end else begin
			dbm = (4 * (floor_dbm + raw) + snr) / 4;
		end
		if (cur_bw500 && int'(cur_sf) >= SF_LO && int'(cur_sf) <= SF_HI) begin
			sens = SF_SENS[int'(cur_sf) - SF_LO];
		end else begin
			sens = floor_dbm + FALLBACK_OFFSET;
		end
		span = PEAK_DBM - sens;
		gap = PEAK_DBM - dbm;
		den = span * span;
		num = 100 * den - gap * (25 * span + 75 * gap);
		q = num / den;
		if (q < 0) begin
			q = 0;
		end
		if (q > 100) begin
			q = 100;
		end
		r.rssi_dbm = 9'(dbm);
		r.snr_quarter_db = p.raw_snr;
		r.lq_pct = 7'(q);
		return r;
	endfunction

	function automatic pkt_t random_pkt();
		pkt_t p;
		p.raw_snr = 8'($urandom_range(255));
		p.rssi_code = 8'($urandom_range(255));
		if ($urandom_range(7) == 0) begin
			case ($urandom_range(3))
				0: p.raw_snr = -8'sd128;
				1: p.raw_snr = -8'sd1;
				2: p.raw_snr = 8'sd0;
				default: p.raw_snr = 8'sd127;
			endcase
		end
		if ($urandom_range(7) == 0) begin
			p.rssi_code = $urandom_range(1) ? 8'd255 : 8'd0;
		end
		return p;
	endfunction

	task automatic queue_pkt(input int snr, input int rssi);
		pkt_t p;
		p.raw_snr = 8'(snr);
		p.rssi_code = 8'(rssi);
		pkt_words.push_back(p);
		n_pushed++;
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [3:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
			CFG_SPREADING_FACTOR: cur_sf = data;
			CFG_BW_IS_500:        cur_bw500 = data[0];
			CFG_HIGH_BAND:        cur_high_band = data[0];
			default: ;
		endcase
		cfg_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		while (n_checked != n_pushed) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// driver
	always @(posedge clk) begin
		if (pkt_valid && pkt_ready) begin
			lq_expected.push_back(estimate_link(pkt));
			n_sent++;
		end
		if (!pkt_valid || pkt_ready) begin
			if (arst_n && pkt_words.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
				pkt <= pkt_words.pop_front();
				pkt_valid <= 1'b1;
			end else begin
				pkt_valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin : mon
		res_t want;
		res_ready <= arst_n && ($urandom_range(99) >= rx_idle_pct);
		if (res_valid && res_ready) begin
			if (lq_expected.size() == 0) begin
				$display("%0t unexpected result word: rssi_dbm %0d snr %0d lq %0d", $time,
					$signed(res.rssi_dbm), $signed(res.snr_quarter_db), res.lq_pct);
				err_cnt++;
			end else begin
				want = lq_expected.pop_front();
				n_checked++;
				if (res.rssi_dbm !== want.rssi_dbm) begin
					$display("%0t rssi_dbm mismatch: expected %0d, actual %0d", $time,
						$signed(want.rssi_dbm), $signed(res.rssi_dbm));
					err_cnt++;
				end
				if (res.snr_quarter_db !== want.snr_quarter_db) begin
					$display("%0t snr_quarter_db mismatch: expected %0d, actual %0d", $time,
						$signed(want.snr_quarter_db), $signed(res.snr_quarter_db));
					err_cnt++;
				end
				if (res.lq_pct !== want.lq_pct) begin
					$display("%0t lq_pct mismatch: expected %0d, actual %0d", $time,
						want.lq_pct, res.lq_pct);
					err_cnt++;
				end
			end
		end
	end

	initial begin
		#2000000;
		$display("timeout with %0d words outstanding", lq_expected.size());
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset settings, field extremes and rounding corners
		queue_pkt(-128, 0);   queue_pkt(-128, 255); queue_pkt(127, 0);   queue_pkt(127, 255);
		queue_pkt(0, 0);      queue_pkt(0, 255);    queue_pkt(-1, 0);    queue_pkt(-1, 255);
		queue_pkt(1, 128);    queue_pkt(-4, 100);   queue_pkt(-3, 100);  queue_pkt(-5, 1);
		queue_pkt(0, 15);     queue_pkt(0, 14);     queue_pkt(-2, 157);  queue_pkt(64, 170);
		queue_pkt(-64, 60);   queue_pkt(0, 200);    queue_pkt(5, 90);    queue_pkt(-100, 30);
		wait_drained();

		for (int i = 0; i < N_PLANS; i++) begin
			if (i < 4) begin
				tx_idle_pct = 14;
				rx_idle_pct = 68;
			end else if (i < 8) begin
				tx_idle_pct = 68;
				rx_idle_pct = 14;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			if (i == 6) begin
				write_reg(CFG_INDEX_UNUSED, 4'($urandom_range(15)));
			end
			write_reg(CFG_SPREADING_FACTOR, plans[i].sf);
			write_reg(CFG_BW_IS_500, plans[i].bw);
			write_reg(CFG_HIGH_BAND, plans[i].hb);
			for (int k = 0; k < ITEMS_PER_PLAN; k++) begin
				pkt_words.push_back(random_pkt());
				n_pushed++;
				// hold the sender until the pipe has emptied once
				if (i == 1 && k == ITEMS_PER_PLAN / 2) begin
					wait_drained();
				end
			end
			wait_drained();
		end

		$display("sent %0d packets across %0d register settings, %0d result words checked",
			n_sent, N_PLANS + 1, n_checked);
		$display("covered both bands, table and fallback sensitivity, mixed stall patterns");
		if (err_cnt == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches", err_cnt);
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
